// ===== rtl/core/mekf_pkg.sv =====
// Shared types and constants for the mutually exclusive key filter.
// Used by mekf_ctrl, mekf_dp and mutually_exclusive_key_filter.
package mekf_pkg;

	localparam int KEY_SLOTS = 36;
	localparam int SLOT_W    = 6;
	localparam int NUM_PRESETS = 3;

	typedef logic [KEY_SLOTS-1:0] key_mask_t;
	typedef logic [SLOT_W-1:0]    slot_t;

	// Operation codes
	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_CHECK   = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_KEYUP   = 2'd0;
	localparam logic [1:0] KIND_PRESS   = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;
	localparam logic [1:0] KIND_CHECK   = 2'd3;

	// Register indexes
	localparam logic [2:0] CFG_ENABLE   = 3'd0;
	localparam logic [2:0] CFG_PRESETS  = 3'd1;
	localparam logic [2:0] CFG_CUSTOM_A = 3'd2;
	localparam logic [2:0] CFG_LAST     = 3'd6;

	// Character codes
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_W = 8'h57;
	localparam logic [7:0] CH_Z = 8'h5A;

	localparam int LETTER_BASE = 10;

	// Preset masks: letters sit at slot 10 + (ch - 'A')
	localparam key_mask_t MASK_WS =
		(key_mask_t'(1) << (LETTER_BASE + int'(CH_W - CH_A))) |
		(key_mask_t'(1) << (LETTER_BASE + int'(CH_S - CH_A)));
	localparam key_mask_t MASK_AD =
		(key_mask_t'(1) << LETTER_BASE) |
		(key_mask_t'(1) << (LETTER_BASE + int'(CH_D - CH_A)));

	// Controller commands and datapath status
	typedef struct packed {
		logic load;
		logic lookup;
		logic scan;
		logic finish;
	} mekf_cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       scan_hit;
		logic       scan_end;
	} mekf_status_t;

	// Map a key code to {valid, slot}
	function automatic logic [SLOT_W:0] key_slot(input logic [7:0] code);
		logic [7:0] d;
		d = 8'd0;
		if (code >= CH_0 && code <= CH_9) begin
			d = code - CH_0;
			return {1'b1, d[SLOT_W-1:0]};
		end else if (code >= CH_A && code <= CH_Z) begin
			d = code - CH_A + 8'(LETTER_BASE);
			return {1'b1, d[SLOT_W-1:0]};
		end
		return {1'b0, slot_t'(0)};
	endfunction

	// Key code of a slot
	function automatic logic [7:0] slot_code(input slot_t s);
		if (s < slot_t'(LETTER_BASE)) begin
			return CH_0 + {2'b00, s};
		end
		return CH_A + {2'b00, s} - 8'(LETTER_BASE);
	endfunction

endpackage

// ===== rtl/core/mekf_ctrl.sv =====
// Controller state machine of the key filter: sequences lookup, slot scan
// and final result. Depends on mekf_pkg.
module mekf_ctrl import mekf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [1:0]   opcode,
	input  mekf_status_t status,
	output mekf_cmd_t    cmd,
	output logic         busy
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOOKUP = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && opcode != OP_NONE) state_next = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (status.opcode == OP_RELEASE) state_next = ST_FINISH;
				else state_next = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_end || (status.opcode == OP_CHECK && status.scan_hit))
					state_next = ST_FINISH;
			end
			ST_FINISH: state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_next;
	end

	// Commands to the datapath
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.lookup = (state_q == ST_LOOKUP);
		cmd.scan   = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_FINISH);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/mekf_dp.sv =====
// Datapath of the key filter: configuration registers, held-key map,
// group lookup, slot scan counter and result registers. Depends on mekf_pkg.
module mekf_dp import mekf_pkg::*; #(
	parameter int NUM_CUSTOM = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	input  mekf_cmd_t    cmd,
	input  logic [1:0]   opcode,
	input  logic [7:0]   key_code,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  key_mask_t    cfg_data,
	output mekf_status_t status,
	output logic         result_strobe,
	output logic [1:0]   result_kind,
	output logic [7:0]   out_key,
	output logic         flag,
	output logic         last_result
);

	localparam int NUM_GROUPS = NUM_PRESETS + NUM_CUSTOM;

	logic            enable_q;
	logic [2:0]      presets_q;
	key_mask_t       custom_q [NUM_CUSTOM];
	key_mask_t       held_q;
	logic [1:0]      opcode_q;
	slot_t           slot_q;
	logic            slot_ok_q;
	key_mask_t       group_q;
	key_mask_t       others_q;
	logic            any_q;
	slot_t           cnt_q;
	logic [7:0]      found_key_q;
	logic            strobe_q;
	logic [1:0]      kind_q;
	logic [7:0]      key_q;
	logic            flag_q;
	logic            last_q;

	logic [SLOT_W:0] slot_in;
	key_mask_t       slot_bit;
	key_mask_t       group_sel;
	logic            cfg_clear;
	logic            hit;

	assign slot_in  = key_slot(key_code);
	assign slot_bit = key_mask_t'(1) << slot_q;
	assign hit      = others_q[cnt_q];
	assign cfg_clear = cfg_we && (cfg_index <= CFG_LAST);

	// First enabled group that holds the key; later candidates lose
	always_comb begin
		key_mask_t cand    [NUM_GROUPS];
		logic      cand_en [NUM_GROUPS];
		cand[0]    = MASK_WS;
		cand_en[0] = presets_q[0];
		cand[1]    = MASK_AD;
		cand_en[1] = presets_q[1];
		cand[2]    = MASK_WS | MASK_AD;
		cand_en[2] = presets_q[2];
		for (int g = 0; g < NUM_CUSTOM; g++) begin
			cand[NUM_PRESETS+g]    = custom_q[g];
			cand_en[NUM_PRESETS+g] = ((custom_q[g] & (custom_q[g] - key_mask_t'(1))) != '0);
		end
		group_sel = '0;
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (cand_en[g] && (cand[g] & slot_bit) != '0) group_sel = cand[g];
		end
		if (!enable_q || !slot_ok_q) group_sel = '0;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			presets_q <= 3'd0;
			for (int g = 0; g < NUM_CUSTOM; g++) custom_q[g] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ENABLE) enable_q <= cfg_data[0];
			if (cfg_index == CFG_PRESETS) presets_q <= cfg_data[2:0];
			for (int g = 0; g < NUM_CUSTOM; g++) begin
				if (cfg_index == CFG_CUSTOM_A + 3'(g)) custom_q[g] <= cfg_data;
			end
		end
	end

	// Held-key map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cfg_clear) begin
			held_q <= '0;
		end else if (cmd.finish) begin
			if (opcode_q == OP_PRESS && group_q != '0)
				held_q <= (held_q & ~others_q) | slot_bit;
			else if (opcode_q == OP_RELEASE && enable_q && slot_ok_q)
				held_q <= held_q & ~slot_bit;
		end
	end

	// Transaction capture, lookup and scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opcode_q  <= opcode;
			slot_q    <= slot_in[SLOT_W-1:0];
			slot_ok_q <= slot_in[SLOT_W];
		end
		if (cmd.lookup) begin
			group_q     <= group_sel;
			others_q    <= held_q & group_sel & ~slot_bit;
			any_q       <= ((held_q & group_sel & ~slot_bit) != '0);
			cnt_q       <= '0;
			found_key_q <= 8'd0;
		end
		if (cmd.scan) begin
			cnt_q <= cnt_q + slot_t'(1);
			if (hit && opcode_q == OP_CHECK) found_key_q <= slot_code(cnt_q);
		end
	end

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe_q <= 1'b0;
		else strobe_q <= (cmd.scan && hit && opcode_q == OP_PRESS) || cmd.finish;
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			kind_q <= KIND_KEYUP;
			key_q  <= slot_code(cnt_q);
			flag_q <= 1'b0;
			last_q <= 1'b0;
		end else if (cmd.finish) begin
			last_q <= 1'b1;
			case (opcode_q)
				OP_PRESS: begin
					kind_q <= KIND_PRESS;
					key_q  <= 8'd0;
					flag_q <= any_q;
				end
				OP_CHECK: begin
					kind_q <= KIND_CHECK;
					key_q  <= found_key_q;
					flag_q <= any_q;
				end
				default: begin
					kind_q <= KIND_RELEASE;
					key_q  <= 8'd0;
					flag_q <= 1'b0;
				end
			endcase
		end
	end

	assign status.opcode   = opcode_q;
	assign status.scan_hit = hit;
	assign status.scan_end = (cnt_q == slot_t'(KEY_SLOTS - 1));

	assign result_strobe = strobe_q;
	assign result_kind   = kind_q;
	assign out_key       = key_q;
	assign flag          = flag_q;
	assign last_result   = last_q;

endmodule

// ===== rtl/core/mutually_exclusive_key_filter.sv =====
// Mutually exclusive key filter, top level. Press walks all 36 key slots
// through one scan counter and check walks them until the first held key
// of the group; key-ups come at most one per cycle during the scan, and a
// release skips the scan. One transaction at a time; busy stays high until
// the final result is registered. Results cannot be stalled. Reset clears the
// configuration registers and held-key map; a write to index 0 to 6 clears the map too.
module mutually_exclusive_key_filter import mekf_pkg::*; #(
	parameter int NUM_CUSTOM = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [1:0]      opcode,
	input  logic [7:0]      key_code,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [KEY_SLOTS-1:0] cfg_data,
	output logic            result_strobe,
	output logic [1:0]      result_kind,
	output logic [7:0]      out_key,
	output logic            flag,
	output logic            last_result
);

	mekf_cmd_t    cmd;
	mekf_status_t status;

	mekf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	mekf_dp #(
		.NUM_CUSTOM (NUM_CUSTOM)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.key_code      (key_code),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.status        (status),
		.result_strobe (result_strobe),
		.result_kind   (result_kind),
		.out_key       (out_key),
		.flag          (flag),
		.last_result   (last_result)
	);

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for mutually_exclusive_key_filter.
// Needs mekf_pkg and the filter RTL. A scripted key-event table runs first,
// then random configurations and events, checked against a local model or table values.
module tb_top;
	import mekf_pkg::*;

	localparam int NUM_CUSTOM    = 5;
	localparam int RANDOM_EVENTS = 370;
	localparam int CALM_TAIL     = 60;
	localparam int DRAIN_CYCLES  = 48;

	localparam logic [2:0] CFG_CUSTOM_B = CFG_CUSTOM_A + 3'd1;
	localparam logic [2:0] CFG_CUSTOM_C = CFG_CUSTOM_A + 3'd2;
	localparam logic [2:0] CFG_CUSTOM_D = CFG_CUSTOM_A + 3'd3;
	localparam logic [2:0] CFG_CUSTOM_E = CFG_LAST;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] key;
		logic       flag;
		logic       last;
	} key_report_t;

	typedef enum logic {ROW_WRITE, ROW_EVENT} row_kind_t;
	typedef enum int {STYLE_NONE, STYLE_SINGLE, STYLE_FEW, STYLE_ANY, STYLE_FULL} mask_style_t;

	typedef struct {
		row_kind_t   what;
		logic [2:0]  idx;
		key_mask_t   data;
		logic [1:0]  op;
		logic [7:0]  code;
		bit          typed;
		key_report_t want;
	} plan_row_t;

	// Block ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  opcode = OP_NONE;
	logic [7:0]  key_code = 8'h00;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_ENABLE;
	key_mask_t   cfg_data = '0;
	logic        result_strobe;
	logic [1:0]  result_kind;
	logic [7:0]  out_key;
	logic        flag;
	logic        last_result;

	// Model of the filter registers and held-key map
	logic        m_enable;
	logic [2:0]  m_presets;
	key_mask_t   m_custom [NUM_CUSTOM];
	key_mask_t   m_held;

	key_report_t owed_reports[$];
	plan_row_t   plan[$];
	int          failures = 0;

	mutually_exclusive_key_filter #(
		.NUM_CUSTOM(NUM_CUSTOM)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.key_code     (key_code),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_strobe(result_strobe),
		.result_kind  (result_kind),
		.out_key      (out_key),
		.flag         (flag),
		.last_result  (last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Append a report to the owed list
	function automatic void owe_report(input key_report_t r);
		owed_reports = {owed_reports, r};
	endfunction

	// Append a row to the stimulus table
	function automatic void add_row(input plan_row_t r);
		plan = {plan, r};
	endfunction

	// Key code of a slot: digits first, then letters
	function automatic logic [7:0] slot_char(input int s);
		if (s < LETTER_BASE)
			return CH_0 + 8'(s);
		return CH_A + 8'(s - LETTER_BASE);
	endfunction

	// First enabled group containing the slot, or zero
	function automatic key_mask_t owning_group(input int slot);
		key_mask_t b;
		b = key_mask_t'(1) << slot;
		if (m_presets[0] && (MASK_WS & b) != 0)
			return MASK_WS;
		if (m_presets[1] && (MASK_AD & b) != 0)
			return MASK_AD;
		if (m_presets[2] && ((MASK_WS | MASK_AD) & b) != 0)
			return MASK_WS | MASK_AD;
		for (int i = 0; i < NUM_CUSTOM; i++)
			if ($countones(m_custom[i]) >= 2 && (m_custom[i] & b) != 0)
				return m_custom[i];
		return '0;
	endfunction

	// Union of all usable groups, used to aim random keys
	function automatic key_mask_t grouped_keys();
		key_mask_t pool;
		pool = '0;
		if (m_presets[0])
			pool |= MASK_WS;
		if (m_presets[1] || m_presets[2])
			pool |= MASK_AD;
		if (m_presets[2])
			pool |= MASK_WS;
		for (int i = 0; i < NUM_CUSTOM; i++)
			if ($countones(m_custom[i]) >= 2)
				pool |= m_custom[i];
		return pool;
	endfunction

	// Work out the reports of one key event and update the held map
	function automatic void predict_key_event(input logic [1:0] op, input logic [7:0] code);
		int          slot;
		key_mask_t   grp;
		key_mask_t   others;
		logic [7:0]  first_key;
		slot = -1;
		if (code >= CH_0 && code <= CH_9)
			slot = int'(code - CH_0);
		else if (code >= CH_A && code <= CH_Z)
			slot = LETTER_BASE + int'(code - CH_A);
		if (op == OP_NONE)
			return;
		grp = '0;
		if (m_enable && slot >= 0)
			grp = owning_group(slot);
		others = '0;
		if (grp != 0)
			others = m_held & grp & ~(key_mask_t'(1) << slot);
		case (op)
			OP_PRESS: begin
				if (grp != 0) begin
					for (int s = 0; s < KEY_SLOTS; s++)
						if (others[s])
							owe_report('{KIND_KEYUP, slot_char(s), 1'b0, 1'b0});
					m_held = (m_held & ~others) | (key_mask_t'(1) << slot);
				end
				owe_report('{KIND_PRESS, 8'h00, others != 0, 1'b1});
			end
			OP_RELEASE: begin
				if (m_enable && slot >= 0)
					m_held[slot] = 1'b0;
				owe_report('{KIND_RELEASE, 8'h00, 1'b0, 1'b1});
			end
			default: begin
				first_key = 8'h00;
				for (int s = KEY_SLOTS - 1; s >= 0; s--)
					if (others[s])
						first_key = slot_char(s);
				owe_report('{KIND_CHECK, first_key, others != 0, 1'b1});
			end
		endcase
	endfunction

	function automatic key_mask_t draw_mask(input mask_style_t style);
		key_mask_t m;
		m = '0;
		case (style)
			STYLE_NONE:   m = '0;
			STYLE_SINGLE: m[$urandom_range(0, KEY_SLOTS - 1)] = 1'b1;
			STYLE_FEW:
				repeat ($urandom_range(2, 4))
					m[$urandom_range(0, KEY_SLOTS - 1)] = 1'b1;
			STYLE_ANY:    m = key_mask_t'({$urandom, $urandom});
			default:      m = '1;
		endcase
		return m;
	endfunction

	function automatic plan_row_t write_row(input logic [2:0] idx, input key_mask_t data);
		plan_row_t r;
		r = '{ROW_WRITE, idx, data, OP_NONE, 8'h00, 1'b0, '0};
		return r;
	endfunction

	function automatic plan_row_t event_row(input logic [1:0] op, input logic [7:0] code);
		plan_row_t r;
		r = '{ROW_EVENT, CFG_ENABLE, '0, op, code, 1'b0, '0};
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic [1:0] op, input logic [7:0] code,
			input logic [1:0] kind, input logic [7:0] key, input logic f);
		plan_row_t r;
		r = '{ROW_EVENT, CFG_ENABLE, '0, op, code, 1'b1, '{kind, key, f, 1'b1}};
		return r;
	endfunction

	// Offer one key event and wait for the block to take it
	task automatic issue(input logic [1:0] op, input logic [7:0] code,
			input bit typed, input key_report_t want);
		int n0;
		start    <= 1'b1;
		opcode   <= op;
		key_code <= code;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		n0 = owed_reports.size();
		predict_key_event(op, code);
		if (typed) begin
			while (owed_reports.size() > n0)
				void'(owed_reports.pop_back());
			owe_report(want);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input key_mask_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_ENABLE:  m_enable  = val[0];
			CFG_PRESETS: m_presets = val[2:0];
			default:     m_custom[idx - CFG_CUSTOM_A] = val;
		endcase
		m_held = '0;
	endtask

	// Let the block go idle before touching its registers
	task automatic settle_block();
		start <= 1'b0;
		while (owed_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endtask

	// Compare each report with the oldest one owed
	always @(posedge clk) begin
		key_report_t want;
		if (arst_n && result_strobe) begin
			if (owed_reports.size() == 0) begin
				$error("result_kind mismatch: expected none, actual %0h", result_kind);
				failures++;
			end else begin
				want = owed_reports.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("out_key", want.key, out_key);
				check_field("flag", want.flag, flag);
				check_field("last_result", want.last, last_result);
			end
		end
	end

	// Stimulus
	initial begin
		int          done;
		int          phase;
		int          len;
		int          pick;
		bit          gappy;
		bit          layered;
		key_mask_t   val;
		key_mask_t   pool;
		logic [1:0]  op;
		logic [7:0]  code;
		mask_style_t style;
		int          s;

		m_enable  = 1'b0;
		m_presets = '0;
		foreach (m_custom[i])
			m_custom[i] = '0;
		m_held = '0;

		// Out of reset: filter off, nothing grouped
		add_row(known_row(OP_PRESS, CH_W, KIND_PRESS, 8'h00, 1'b0));
		add_row(known_row(OP_CHECK, CH_W, KIND_CHECK, 8'h00, 1'b0));
		add_row(known_row(OP_RELEASE, 8'hFF, KIND_RELEASE, 8'h00, 1'b0));
		add_row(event_row(OP_NONE, 8'h00));
		// Enabled but no usable group
		add_row(write_row(CFG_ENABLE, '1));
		add_row(known_row(OP_PRESS, CH_A, KIND_PRESS, 8'h00, 1'b0));
		add_row(known_row(OP_CHECK, CH_A, KIND_CHECK, 8'h00, 1'b0));
		// Single-key mask does not form a group
		add_row(write_row(CFG_CUSTOM_B, key_mask_t'(1) << LETTER_BASE));
		add_row(known_row(OP_PRESS, CH_A, KIND_PRESS, 8'h00, 1'b0));
		add_row(known_row(OP_RELEASE, CH_A, KIND_RELEASE, 8'h00, 1'b0));
		// All presets, catch-all custom group, shadowed digit groups
		add_row(write_row(CFG_PRESETS, '1));
		add_row(write_row(CFG_CUSTOM_A, '1));
		add_row(write_row(CFG_CUSTOM_C, 36'h3FF));
		add_row(write_row(CFG_CUSTOM_D, '0));
		add_row(write_row(CFG_CUSTOM_E, 36'h3));
		add_row(event_row(OP_PRESS, CH_0));
		add_row(event_row(OP_PRESS, CH_9));
		add_row(event_row(OP_PRESS, CH_Z));
		add_row(event_row(OP_PRESS, CH_W));
		add_row(event_row(OP_PRESS, CH_A));
		add_row(event_row(OP_CHECK, CH_W));
		add_row(event_row(OP_PRESS, CH_S));
		add_row(event_row(OP_CHECK, CH_W));
		add_row(event_row(OP_PRESS, CH_W));
		// Digit press drops A, W and Z held by other groups
		add_row(event_row(OP_PRESS, CH_0 + 8'd5));
		// Release of a grouped key that is not held
		add_row(known_row(OP_RELEASE, CH_W, KIND_RELEASE, 8'h00, 1'b0));
		add_row(event_row(OP_CHECK, CH_0 + 8'd5));
		// Ungrouped codes and the unused opcode
		add_row(known_row(OP_PRESS, 8'h00, KIND_PRESS, 8'h00, 1'b0));
		add_row(known_row(OP_CHECK, 8'h7F, KIND_CHECK, 8'h00, 1'b0));
		add_row(known_row(OP_RELEASE, 8'h80, KIND_RELEASE, 8'h00, 1'b0));
		add_row(event_row(OP_NONE, CH_D));
		add_row(known_row(OP_PRESS, 8'hFF, KIND_PRESS, 8'h00, 1'b0));

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scripted part
		foreach (plan[i]) begin
			if (plan[i].what == ROW_WRITE) begin
				if (!cfg_we)
					settle_block();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				if (cfg_we)
					cfg_we <= 1'b0;
				issue(plan[i].op, plan[i].code, plan[i].typed, plan[i].want);
			end
		end

		// Random part: new settings per phase, first two phases at the extremes
		done  = 0;
		phase = 0;
		while (done < RANDOM_EVENTS) begin
			settle_block();
			layered = ($urandom_range(0, 2) == 0);
			for (int r = CFG_ENABLE; r <= CFG_LAST; r++) begin
				if (r == CFG_ENABLE) begin
					val = key_mask_t'({$urandom, $urandom});
					val[0] = (phase < 2) || ($urandom_range(0, 5) != 0);
				end else if (r == CFG_PRESETS) begin
					if (phase == 0)
						val = '1;
					else if (phase == 1)
						val = '0;
					else
						val = key_mask_t'({$urandom, $urandom});
				end else begin
					if (phase == 0)
						style = STYLE_FULL;
					else if (phase == 1)
						style = STYLE_SINGLE;
					else if (layered)
						style = (r == CFG_LAST) ? STYLE_FULL : STYLE_FEW;
					else
						style = mask_style_t'($urandom_range(STYLE_NONE, STYLE_FULL));
					val = draw_mask(style);
				end
				write_reg(3'(r), val);
			end
			cfg_we <= 1'b0;

			len   = $urandom_range(25, 60);
			gappy = ($urandom_range(0, 2) != 0);
			pool  = grouped_keys();
			for (int k = 0; k < len && done < RANDOM_EVENTS; k++) begin
				pick = $urandom_range(0, 19);
				if (pick < 10)
					op = OP_PRESS;
				else if (pick < 14)
					op = OP_RELEASE;
				else if (pick < 19)
					op = OP_CHECK;
				else
					op = OP_NONE;
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					code = 8'($urandom_range(0, 255));
				end else if (pick < 25 || pool == 0) begin
					code = slot_char($urandom_range(0, KEY_SLOTS - 1));
				end else begin
					do
						s = $urandom_range(0, KEY_SLOTS - 1);
					while (!pool[s]);
					code = slot_char(s);
				end
				// Sender pauses, none near the end
				if (gappy && done < RANDOM_EVENTS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 18))
						@(posedge clk);
				end
				issue(op, code, 1'b0, '0);
				if (op != OP_NONE)
					done++;
			end
			phase++;
		end

		start <= 1'b0;
		while (owed_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

endmodule
